// ----- sv/mhpq_pkg.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mhpq_pkg
// Shared types and codes for the min-heap priority queue core.
// ----------------------------------------------------------------------------
package mhpq_pkg;

	localparam int DEF_CAPACITY = 1024;

	localparam int ID_W    = 16;
	localparam int COST_W  = 24;
	localparam int KIND_W  = 2;
	localparam int STAT_W  = 3;
	localparam int COUNT_W = 11;

	localparam logic [KIND_W-1:0] KIND_INSERT   = 2'd0;
	localparam logic [KIND_W-1:0] KIND_DECREASE = 2'd1;
	localparam logic [KIND_W-1:0] KIND_EXTRACT  = 2'd2;

	localparam logic [STAT_W-1:0] ST_OK          = 3'd0;
	localparam logic [STAT_W-1:0] ST_FULL        = 3'd1;
	localparam logic [STAT_W-1:0] ST_NOT_FOUND   = 3'd2;
	localparam logic [STAT_W-1:0] ST_EMPTY       = 3'd3;
	localparam logic [STAT_W-1:0] ST_NOT_CHEAPER = 3'd4;

	typedef struct packed {
		logic [KIND_W-1:0] kind;
		logic [ID_W-1:0]   item_id;
		logic [COST_W-1:0] cost;
	} cmd_t;

	typedef struct packed {
		logic [STAT_W-1:0]  status;
		logic [ID_W-1:0]    min_item_id;
		logic [COUNT_W-1:0] entry_count;
	} res_t;

	typedef struct packed {
		logic [ID_W-1:0]   id;
		logic [COST_W-1:0] cost;
	} entry_t;

endpackage

// ----- sv/mhpq_heap_ram.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mhpq_heap_ram
// Heap entry store: one write port, one read port with registered data.
// ----------------------------------------------------------------------------
module mhpq_heap_ram #(
	parameter int DEPTH = 1024,
	parameter int AW    = 10
) (
	input  logic                 clk,
	input  logic                 we,
	input  logic [AW-1:0]        waddr,
	input  mhpq_pkg::entry_t     wdata,
	input  logic                 re,
	input  logic [AW-1:0]        raddr,
	output mhpq_pkg::entry_t     rdata
);
	import mhpq_pkg::*;

	entry_t mem [DEPTH];
	entry_t rdata_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
	end

	always_ff @(posedge clk) begin
		if (re) begin
			rdata_q <= mem[raddr];
		end
	end

	assign rdata = rdata_q;

endmodule

// ----- sv/mhpq_ctrl.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mhpq_ctrl
// Heap sequencer: id scan, sift-up and sift-down over one shared cost comparator.
// ----------------------------------------------------------------------------
module mhpq_ctrl #(
	parameter int CAPACITY = 1024,
	parameter int AW       = 10,
	parameter int CW       = 11
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              start,
	input  mhpq_pkg::cmd_t    cmd,
	output logic              busy,
	output logic              fin,
	output mhpq_pkg::res_t    fin_res,
	output logic              we,
	output logic [AW-1:0]     waddr,
	output mhpq_pkg::entry_t  wdata,
	output logic              re,
	output logic [AW-1:0]     raddr,
	input  mhpq_pkg::entry_t  rdata
);
	import mhpq_pkg::*;

	localparam int XW = AW + 2;

	typedef enum logic [10:0] {
		S_IDLE    = 11'b00000000001,
		S_SCAN_CK = 11'b00000000010,
		S_UP_RD   = 11'b00000000100,
		S_UP_CK   = 11'b00000001000,
		S_EX_LAST = 11'b00000010000,
		S_EX_LOAD = 11'b00000100000,
		S_DN_L    = 11'b00001000000,
		S_DN_R    = 11'b00010000000,
		S_DN_CK   = 11'b00100000000,
		S_DN_SW   = 11'b01000000000,
		S_SPARE   = 11'b10000000000
	} state_t;

	state_t            state_q, state_d;
	logic [CW-1:0]     count_q, count_d;
	logic [AW-1:0]     pos_q, pos_d;
	logic [AW-1:0]     idx_q, idx_d;
	logic [AW-1:0]     pick_pos_q, pick_pos_d;
	entry_t            cur_q, cur_d;
	entry_t            lch_q, lch_d;
	entry_t            pick_q, pick_d;
	logic [STAT_W-1:0] status_q, status_d;
	logic [ID_W-1:0]   min_q, min_d;

	logic [COST_W-1:0] cmp_a, cmp_b;
	logic              lt;
	logic [AW-1:0]     par;
	logic [CW-1:0]     idx_next;
	logic [CW-1:0]     cnt_m1;
	logic [XW-1:0]     lft, rgt, cnt_x;
	logic              has_r;

	// shared cost comparator
	always_comb begin
		unique case (state_q)
			S_DN_CK: begin
				cmp_a = lch_q.cost;
				cmp_b = rdata.cost;
			end
			S_DN_SW: begin
				cmp_a = pick_q.cost;
				cmp_b = cur_q.cost;
			end
			default: begin
				cmp_a = cur_q.cost;
				cmp_b = rdata.cost;
			end
		endcase
	end
	assign lt = cmp_a < cmp_b;

	assign par      = (pos_q - AW'(1)) >> 1;
	assign idx_next = CW'(idx_q) + CW'(1);
	assign cnt_m1   = count_q - CW'(1);
	assign lft      = XW'({pos_q, 1'b1});
	assign rgt      = lft + XW'(1);
	assign cnt_x    = XW'(count_q);
	assign has_r    = rgt < cnt_x;

	always_comb begin
		state_d    = state_q;
		count_d    = count_q;
		pos_d      = pos_q;
		idx_d      = idx_q;
		pick_pos_d = pick_pos_q;
		cur_d      = cur_q;
		lch_d      = lch_q;
		pick_d     = pick_q;
		status_d   = status_q;
		min_d      = min_q;
		fin        = 1'b0;
		we         = 1'b0;
		waddr      = pos_q;
		wdata      = cur_q;
		re         = 1'b0;
		raddr      = '0;
		unique case (state_q)
			S_IDLE: begin
				if (start) begin
					status_d = ST_OK;
					min_d    = '0;
					cur_d    = '{id: cmd.item_id, cost: cmd.cost};
					unique case (cmd.kind)
						KIND_INSERT: begin
							if (count_q >= CW'(CAPACITY)) begin
								status_d = ST_FULL;
								fin      = 1'b1;
							end else begin
								pos_d   = count_q[AW-1:0];
								count_d = count_q + CW'(1);
								state_d = S_UP_RD;
							end
						end
						KIND_DECREASE: begin
							if (count_q == '0) begin
								status_d = ST_NOT_FOUND;
								fin      = 1'b1;
							end else begin
								re      = 1'b1;
								idx_d   = '0;
								state_d = S_SCAN_CK;
							end
						end
						KIND_EXTRACT: begin
							if (count_q == '0) begin
								status_d = ST_EMPTY;
								fin      = 1'b1;
							end else begin
								re      = 1'b1;
								state_d = S_EX_LAST;
							end
						end
						default: begin
							fin = 1'b1;
						end
					endcase
				end
			end
			S_SCAN_CK: begin
				if (rdata.id == cur_q.id) begin
					if (!lt) begin
						status_d = ST_NOT_CHEAPER;
						fin      = 1'b1;
						state_d  = S_IDLE;
					end else begin
						pos_d   = idx_q;
						state_d = S_UP_RD;
					end
				end else if (idx_next >= count_q) begin
					status_d = ST_NOT_FOUND;
					fin      = 1'b1;
					state_d  = S_IDLE;
				end else begin
					re    = 1'b1;
					raddr = idx_next[AW-1:0];
					idx_d = idx_next[AW-1:0];
				end
			end
			S_UP_RD: begin
				if (pos_q == '0) begin
					we      = 1'b1;
					fin     = 1'b1;
					state_d = S_IDLE;
				end else begin
					re      = 1'b1;
					raddr   = par;
					state_d = S_UP_CK;
				end
			end
			S_UP_CK: begin
				we = 1'b1;
				if (lt) begin
					wdata   = rdata;
					pos_d   = par;
					state_d = S_UP_RD;
				end else begin
					fin     = 1'b1;
					state_d = S_IDLE;
				end
			end
			S_EX_LAST: begin
				min_d   = rdata.id;
				count_d = cnt_m1;
				if (cnt_m1 == '0) begin
					fin     = 1'b1;
					state_d = S_IDLE;
				end else begin
					re      = 1'b1;
					raddr   = cnt_m1[AW-1:0];
					state_d = S_EX_LOAD;
				end
			end
			S_EX_LOAD: begin
				cur_d   = rdata;
				pos_d   = '0;
				state_d = S_DN_L;
			end
			S_DN_L: begin
				if (lft >= cnt_x) begin
					we      = 1'b1;
					fin     = 1'b1;
					state_d = S_IDLE;
				end else begin
					re      = 1'b1;
					raddr   = lft[AW-1:0];
					state_d = S_DN_R;
				end
			end
			S_DN_R: begin
				lch_d = rdata;
				if (has_r) begin
					re    = 1'b1;
					raddr = rgt[AW-1:0];
				end
				state_d = S_DN_CK;
			end
			S_DN_CK: begin
				// ties go to the right child
				if (has_r && !lt) begin
					pick_d     = rdata;
					pick_pos_d = rgt[AW-1:0];
				end else begin
					pick_d     = lch_q;
					pick_pos_d = lft[AW-1:0];
				end
				state_d = S_DN_SW;
			end
			S_DN_SW: begin
				we = 1'b1;
				if (lt) begin
					wdata   = pick_q;
					pos_d   = pick_pos_q;
					state_d = S_DN_L;
				end else begin
					fin     = 1'b1;
					state_d = S_IDLE;
				end
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			count_q <= '0;
		end else begin
			state_q <= state_d;
			count_q <= count_d;
		end
	end

	always_ff @(posedge clk) begin
		pos_q      <= pos_d;
		idx_q      <= idx_d;
		pick_pos_q <= pick_pos_d;
		cur_q      <= cur_d;
		lch_q      <= lch_d;
		pick_q     <= pick_d;
		status_q   <= status_d;
		min_q      <= min_d;
	end

	assign busy                = state_q != S_IDLE;
	assign fin_res.status      = status_d;
	assign fin_res.min_item_id = min_d;
	assign fin_res.entry_count = COUNT_W'(count_d);

endmodule

// ----- sv/min_heap_priority_queue_core.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// min_heap_priority_queue_core
// Binary min-heap of (item id, cost) entries with insert, decrease and extract.
// ----------------------------------------------------------------------------
// usage
//   command channel: a transaction is taken on a rising edge with start high
//   and busy low; cmd carries kind, item_id and cost
//   result channel: done is high for exactly one cycle with the result on
//   result; it follows in the cycle after the last step of the operation and the
//   receiver cannot stall it, so the result register never holds off work
//   steps per operation:
//     full insert, empty extract, decrease of empty heap, unused kind: the
//       result follows straight from idle without touching the heap
//     insert: sift-up from the new last slot, one parent read and compare
//       per level moved up
//     decrease: id scan from slot 0, then a sift-up when the new cost is lower
//     extract: root id taken, last entry moved to the root and sifted down
//   busy stays high while the sequencer walks the heap; all steps share one
//   cost comparator and the single read port of the entry memory, one read
//   per cycle
//   reset empties the heap at once; entry memory needs no clearing pass
// ----------------------------------------------------------------------------
module min_heap_priority_queue_core #(
	parameter int CAPACITY = mhpq_pkg::DEF_CAPACITY
) (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            start,
	input  mhpq_pkg::cmd_t  cmd,
	output logic            busy,
	output logic            done,
	output mhpq_pkg::res_t  result
);
	import mhpq_pkg::*;

	localparam int AW = $clog2(CAPACITY);
	localparam int CW = $clog2(CAPACITY + 1);

	logic          fin;
	res_t          fin_res;
	logic          we, re;
	logic [AW-1:0] waddr, raddr;
	entry_t        wdata, rdata;
	logic          done_q;
	res_t          result_q;

	mhpq_ctrl #(
		.CAPACITY (CAPACITY),
		.AW       (AW),
		.CW       (CW)
	) u_ctrl (
		.clk     (clk),
		.arst_n  (arst_n),
		.start   (start),
		.cmd     (cmd),
		.busy    (busy),
		.fin     (fin),
		.fin_res (fin_res),
		.we      (we),
		.waddr   (waddr),
		.wdata   (wdata),
		.re      (re),
		.raddr   (raddr),
		.rdata   (rdata)
	);

	mhpq_heap_ram #(
		.DEPTH (CAPACITY),
		.AW    (AW)
	) u_ram (
		.clk   (clk),
		.we    (we),
		.waddr (waddr),
		.wdata (wdata),
		.re    (re),
		.raddr (raddr),
		.rdata (rdata)
	);

	// result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			done_q <= 1'b0;
		end else begin
			done_q <= fin;
		end
	end

	always_ff @(posedge clk) begin
		if (fin) begin
			result_q <= fin_res;
		end
	end

	assign done   = done_q;
	assign result = result_q;

	a_fell_busy_done: assert property (@(posedge clk) disable iff (!arst_n)
		$fell(busy) |-> done)
		else $error("multi-cycle transaction ended without a result");

	a_full_count: assert property (@(posedge clk) disable iff (!arst_n)
		(done && result.status == ST_FULL) |-> result.entry_count == COUNT_W'(CAPACITY))
		else $error("insert dropped while heap not full");

	a_empty_result: assert property (@(posedge clk) disable iff (!arst_n)
		(done && result.status == ST_EMPTY) |->
		(result.entry_count == '0 && result.min_item_id == '0))
		else $error("empty extract with entries held");

	a_min_only_ok: assert property (@(posedge clk) disable iff (!arst_n)
		(done && result.status != ST_OK) |-> result.min_item_id == '0)
		else $error("item id reported on failed transaction");

endmodule
